### rtl/gdda_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdda_pkg
// shared constants and helpers for gregorian date day arithmetic
// ----------------------------------------------------------------------------
package gdda_pkg;

    localparam int MAX_YEAR = 9999;
    localparam int NUM_W    = 24;

    localparam logic [1:0] MODE_DIFF = 2'd0;
    localparam logic [1:0] MODE_ADD  = 2'd1;
    localparam logic [1:0] MODE_SUB  = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD_A = 2'd1;
    localparam logic [1:0] ST_BAD_B = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // day number of MAX_YEAR-12-31
    localparam int LAST_DAY = 365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100
                              + MAX_YEAR / 400;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] r;
        begin
            case (m)
                4'd2:                                r = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:             r = 5'd30;
                default:                             r = 5'd31;
            endcase
            return r;
        end
    endfunction

endpackage : gdda_pkg
`default_nettype wire

### rtl/gdda_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdda_seq
// sequencer with one shared add/compare unit: date to day number and back
// ----------------------------------------------------------------------------
module gdda_seq
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [1:0]                  mode,
    input  wire logic [13:0]                 year_a,
    input  wire logic [3:0]                  month_a,
    input  wire logic [4:0]                  day_a,
    input  wire logic [13:0]                 year_b,
    input  wire logic [3:0]                  month_b,
    input  wire logic [4:0]                  day_b,
    input  wire logic signed [22:0]          day_offset,
    output logic                             done,
    output logic [1:0]                       status,
    output logic signed [22:0]               day_difference,
    output logic [13:0]                      result_year,
    output logic [3:0]                       result_month,
    output logic [4:0]                       result_day
);

    localparam int W = gdda_pkg::NUM_W + 2;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_CHKA   = 11'b00000000010,
        S_YEARS  = 11'b00000000100,
        S_MONTHS = 11'b00000001000,
        S_CHKB   = 11'b00000010000,
        S_DIFF   = 11'b00000100000,
        S_SHIFT  = 11'b00001000000,
        S_RANGE  = 11'b00010000000,
        S_Y400   = 11'b00100000000,
        S_YR     = 11'b01000000000,
        S_MO     = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]            mode_reg;
    logic [13:0]           yb_reg;
    logic [3:0]            mb_reg;
    logic [4:0]            db_reg;
    logic signed [22:0]    off_reg;
    logic                  side_reg;        // 0 first date, 1 second date
    logic [13:0]           y_reg;           // working year
    logic [3:0]            m_reg;           // working month
    logic [13:0]           cnt_reg;         // year counter
    logic [1:0]            c4_reg;          // year mod 4
    logic [6:0]            c100_reg;        // year mod 100
    logic [8:0]            c400_reg;        // year mod 400
    logic signed [W-1:0]   acc_reg;         // day number accumulator
    logic signed [W-1:0]   na_reg;
    logic [1:0]            st_reg;
    logic signed [22:0]    diff_reg;
    logic [13:0]           ry_reg;
    logic [3:0]            rm_reg;
    logic [4:0]            rd_reg;
    logic                  done_reg;

    // leap flag of the counted year (cnt, mods track cnt)
    logic leap_cnt;
    assign leap_cnt = ((c4_reg == 2'd0) && (c100_reg != 7'd0)) || (c400_reg == 9'd0);

    // shared unit: one signed add and sign compare
    logic signed [W-1:0] op_a, op_b, sum;
    assign sum = op_a + op_b;

    logic [4:0]  mlen;
    logic [8:0]  ylen;
    assign mlen = gdda_pkg::month_len(m_reg, leap_cnt);
    assign ylen = leap_cnt ? 9'd366 : 9'd365;

    // date validity check on the held date
    function automatic logic date_ok(input logic [13:0] y, input logic [3:0] m,
                                     input logic [4:0] d);
        logic [26:0] prod;
        logic [9:0]  q25;
        logic [13:0] r25;
        logic        d25;
        logic        lp;
        begin
            // divisible by 25 through a reciprocal multiply, exact below 16384
            prod = 27'(y) * 27'd5243;
            q25  = prod[26:17];
            r25  = y - 14'(q25) * 14'd25;
            d25  = (r25 == 14'd0);
            lp   = ((y[1:0] == 2'd0) && !d25) || ((y[3:0] == 4'd0) && d25);
            return (y >= 14'd1) && (y <= 14'(gdda_pkg::MAX_YEAR)) && (m >= 4'd1)
                   && (m <= 4'd12) && (d >= 5'd1) && (d <= gdda_pkg::month_len(m, lp));
        end
    endfunction

    logic [13:0] ycur;
    logic [3:0]  mcur;
    logic [4:0]  dcur;
    logic [13:0] ya_reg;
    logic [3:0]  ma_reg;
    logic [4:0]  da_reg;
    assign ycur = side_reg ? yb_reg : ya_reg;
    assign mcur = side_reg ? mb_reg : ma_reg;
    assign dcur = side_reg ? db_reg : da_reg;

    always_comb
    begin
        op_a = acc_reg;
        op_b = '0;
        unique case (state_reg)
            S_YEARS:  op_b = W'(ylen);
            S_MONTHS: op_b = W'(mlen);
            S_DIFF:   op_b = -acc_reg;
            S_SHIFT:  op_b = (mode_reg == gdda_pkg::MODE_ADD) ? W'(off_reg) : -W'(off_reg);
            S_RANGE:  op_b = -W'(gdda_pkg::LAST_DAY + 1);
            S_Y400:   op_b = -W'(146097);
            S_YR:     op_b = -W'(ylen);
            S_MO:     op_b = -W'(mlen);
            default:  op_b = '0;
        endcase
        if (state_reg == S_DIFF)
        begin
            op_a = na_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (start) state_next = (mode == gdda_pkg::MODE_NONE) ? S_IDLE : S_CHKA;
            S_CHKA, S_CHKB:
                      state_next = date_ok(ycur, mcur, dcur) ? S_YEARS : S_IDLE;
            S_YEARS:  if (cnt_reg == y_reg) state_next = S_MONTHS;
            S_MONTHS: if (m_reg == mcur)
                      begin
                          if (side_reg) state_next = S_DIFF;
                          else if (mode_reg == gdda_pkg::MODE_DIFF) state_next = S_CHKB;
                          else state_next = S_SHIFT;
                      end
            S_DIFF:   state_next = S_IDLE;
            S_SHIFT:  state_next = S_RANGE;
            S_RANGE:  state_next = (acc_reg < W'(1) || !sum[W-1]) ? S_IDLE : S_Y400;
            S_Y400:   if (sum <= 0) state_next = S_YR;
            S_YR:     if (sum <= 0) state_next = S_MO;
            S_MO:     if (sum <= 0 || m_reg == 4'd12) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg != S_IDLE) && (state_next == S_IDLE)
                         || (state_reg == S_IDLE && start && mode == gdda_pkg::MODE_NONE);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_reg <= mode;
                    ya_reg <= year_a; ma_reg <= month_a; da_reg <= day_a;
                    yb_reg <= year_b; mb_reg <= month_b; db_reg <= day_b;
                    off_reg <= day_offset;
                    side_reg <= 1'b0;
                    st_reg <= gdda_pkg::ST_OK;
                    diff_reg <= '0; ry_reg <= '0; rm_reg <= '0; rd_reg <= '0;
                end
            end
            S_CHKA, S_CHKB:
            begin
                y_reg <= ycur;
                m_reg <= 4'd1;
                cnt_reg <= 14'd1;
                c4_reg <= 2'd1; c100_reg <= 7'd1; c400_reg <= 9'd1;
                acc_reg <= W'(dcur);
                if (!date_ok(ycur, mcur, dcur))
                    st_reg <= side_reg ? gdda_pkg::ST_BAD_B : gdda_pkg::ST_BAD_A;
            end
            S_YEARS:
            begin
                if (cnt_reg == y_reg)
                begin
                    // leap flags now belong to the target year
                end
                else
                begin
                    acc_reg <= sum;
                    cnt_reg <= cnt_reg + 14'd1;
                    c4_reg <= c4_reg + 2'd1;
                    c100_reg <= (c100_reg == 7'd99) ? 7'd0 : c100_reg + 7'd1;
                    c400_reg <= (c400_reg == 9'd399) ? 9'd0 : c400_reg + 9'd1;
                end
            end
            S_MONTHS:
            begin
                if (m_reg != mcur)
                begin
                    acc_reg <= sum;
                    m_reg <= m_reg + 4'd1;
                end
                else
                begin
                    side_reg <= 1'b1;
                    if (!side_reg) na_reg <= acc_reg;
                end
            end
            S_DIFF:
            begin
                if (sum < -W'(4194304) || sum > W'(4194303))
                    st_reg <= gdda_pkg::ST_RANGE;
                else
                    diff_reg <= sum[22:0];
            end
            S_SHIFT:  acc_reg <= sum;
            S_RANGE:
            begin
                if (acc_reg < W'(1) || !sum[W-1])
                    st_reg <= gdda_pkg::ST_RANGE;
                cnt_reg <= 14'd1;
                c4_reg <= 2'd1; c100_reg <= 7'd1; c400_reg <= 9'd1;
                m_reg <= 4'd1;
            end
            S_Y400:
            begin
                // whole 400-year cycles; mods are unchanged by 400 years
                if (sum > 0)
                begin
                    acc_reg <= sum;
                    cnt_reg <= cnt_reg + 14'd400;
                end
            end
            S_YR:
            begin
                if (sum > 0)
                begin
                    acc_reg <= sum;
                    cnt_reg <= cnt_reg + 14'd1;
                    c4_reg <= c4_reg + 2'd1;
                    c100_reg <= (c100_reg == 7'd99) ? 7'd0 : c100_reg + 7'd1;
                    c400_reg <= (c400_reg == 9'd399) ? 9'd0 : c400_reg + 9'd1;
                end
            end
            S_MO:
            begin
                if (sum > 0 && m_reg != 4'd12)
                begin
                    acc_reg <= sum;
                    m_reg <= m_reg + 4'd1;
                end
                else
                begin
                    ry_reg <= cnt_reg;
                    rm_reg <= m_reg;
                    rd_reg <= acc_reg[4:0];
                end
            end
            default: ;
        endcase
    end

    assign done           = done_reg;
    assign status         = st_reg;
    assign day_difference = diff_reg;
    assign result_year    = ry_reg;
    assign result_month   = rm_reg;
    assign result_day     = rd_reg;

endmodule : gdda_seq
`default_nettype wire

### rtl/gregorian_date_day_arithmetic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gregorian_date_day_arithmetic
// proleptic gregorian date difference and day offset
// ----------------------------------------------------------------------------
// One transaction at a time. A date is turned into a day number by stepping a
// shared adder over the years before it and the months before it; the
// reverse walk steps by 400-year cycles, then by years and months. The
// result waits in an output register; a new transaction is taken once
// that result has been taken.
module gregorian_date_day_arithmetic
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           mode,
    input  wire logic [13:0]          year_a,
    input  wire logic [3:0]           month_a,
    input  wire logic [4:0]           day_a,
    input  wire logic [13:0]          year_b,
    input  wire logic [3:0]           month_b,
    input  wire logic [4:0]           day_b,
    input  wire logic signed [22:0]   day_offset,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [1:0]                status,
    output logic signed [22:0]        day_difference,
    output logic [13:0]               result_year,
    output logic [3:0]                result_month,
    output logic [4:0]                result_day
);

    logic busy_reg, ov_reg;
    logic done;
    logic [1:0]         s_st;
    logic signed [22:0] s_diff;
    logic [13:0]        s_y;
    logic [3:0]         s_m;
    logic [4:0]         s_d;
    logic start;

    assign in_ready = !busy_reg;
    assign start    = in_valid && in_ready;

    gdda_seq u_seq
    (
        .clk(clk), .rst_n(rst_n), .start(start), .mode(mode),
        .year_a(year_a), .month_a(month_a), .day_a(day_a),
        .year_b(year_b), .month_b(month_b), .day_b(day_b),
        .day_offset(day_offset), .done(done), .status(s_st),
        .day_difference(s_diff), .result_year(s_y), .result_month(s_m),
        .result_day(s_d)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (start) busy_reg <= 1'b1;
            else if (ov_reg && out_ready) busy_reg <= 1'b0;
            if (done) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
        end
    end

    assign out_valid      = ov_reg;
    assign status         = s_st;
    assign day_difference = s_diff;
    assign result_year    = s_y;
    assign result_month   = s_m;
    assign result_day     = s_d;

    a_one_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> busy_reg) else $error("result without transaction");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !in_ready) else $error("accept while busy");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(status)
        && $stable(day_difference) && $stable(result_year)
        && $stable(result_month) && $stable(result_day))
        else $error("result dropped or changed while waiting");

endmodule : gregorian_date_day_arithmetic
`default_nettype wire
